FILE: src/gssr_pkg.sv
package gssr_pkg;

	// Field widths fixed by the interface.
	localparam int COORD_IN_W = 13;
	localparam int MAG_W      = 9;
	localparam int COORD_W    = 14;
	localparam int DIM_W      = 12;
	localparam int PIX_W      = 8;
	localparam int SPAN_MAX   = 11;
	localparam int LOW_PIX    = 8;

	// Internal arithmetic widths, sized for the largest supported radius.
	localparam int NBASE_W    = 10;
	localparam int DIST_W     = 6;
	localparam int DIST_SHIFT = 5;
	localparam int N_W        = 12;
	localparam int MAG_BIAS   = 16;

	// Decay table: entry n is the intensity after n steps of e^(-1/16).
	localparam int LUT_DEPTH = 256;
	localparam int STEP_CAP  = 200;
	localparam longint unsigned K_Q24    = 64'd961263668779;
	localparam longint unsigned C_Q24    = 64'd15760736;
	localparam longint unsigned HALF_Q24 = 64'd8388608;

	// Queue between the front and back parts.
	localparam int QDEPTH = 2;
	localparam int PTR_W  = $clog2(QDEPTH);
	localparam int CNT_W  = $clog2(QDEPTH + 1);

	typedef logic [LUT_DEPTH-1:0][PIX_W-1:0] lut_t;

	// One classified star as handed from the front to the back.
	typedef struct packed {
		logic signed [COORD_IN_W-1:0] star_y;
		logic signed [COORD_W-1:0]    first_col;
		logic signed [NBASE_W-1:0]    n_base;
		logic [SPAN_MAX-1:0]          col_mask;
	} star_job_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic             valid;
		logic             full;
		logic [CNT_W-1:0] count;
	} q_status_t;

	function automatic lut_t build_lut();
		lut_t t;
		longint unsigned v;
		longint unsigned r;
		v = K_Q24;
		for (int i = 0; i < LUT_DEPTH; i++) begin
			r = (v + HALF_Q24) >> 24;
			t[i] = (r > 64'd255) ? 8'hFF : r[7:0];
			v = (v * C_Q24 + HALF_Q24) >> 24;
		end
		return t;
	endfunction

	localparam lut_t INT_LUT = build_lut();

	// Intensity for a decay step count; no decay saturates, long decay is zero.
	function automatic logic [PIX_W-1:0] pixel_level(input logic signed [N_W-1:0] n);
		logic [PIX_W-1:0] lv;
		if (n <= 0) begin
			lv = INT_LUT[0];
		end else if (n > STEP_CAP) begin
			lv = '0;
		end else begin
			lv = INT_LUT[n[7:0]];
		end
		return lv;
	endfunction

endpackage

FILE: src/gssr_front.sv
module gssr_front import gssr_pkg::*; #(
	parameter int WINDOW_RADIUS = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         star_valid,
	output logic                         star_ready,
	input  logic signed [COORD_IN_W-1:0] star_x,
	input  logic signed [COORD_IN_W-1:0] star_y,
	input  logic signed [MAG_W-1:0]      star_magnitude,
	input  logic [DIM_W-1:0]             image_width,
	input  q_status_t                    q_stat,
	output logic                         push,
	output star_job_t                    job
);

	localparam int SPAN = 2 * WINDOW_RADIUS + 1;

	logic      valid_s1;
	star_job_t job_s1;
	star_job_t job_c;

	// Classify the star: window origin, decay offset and column clipping.
	always_comb begin
		logic signed [COORD_W-1:0] col;
		job_c.star_y    = star_y;
		job_c.first_col = COORD_W'(star_x) - COORD_W'(WINDOW_RADIUS);
		job_c.n_base    = NBASE_W'(star_magnitude) - NBASE_W'(MAG_BIAS);
		for (int k = 0; k < SPAN_MAX; k++) begin
			col = job_c.first_col + COORD_W'(k);
			job_c.col_mask[k] = (k < SPAN) && (col >= 0) &&
				(col < $signed({2'b00, image_width}));
		end
	end

	assign push       = valid_s1 && !q_stat.full;
	assign star_ready = !valid_s1 || push;
	assign job        = job_s1;

	// Holding stage in front of the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (star_ready) begin
			valid_s1 <= star_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (star_ready && star_valid) begin
			job_s1 <= job_c;
		end
	end

endmodule

FILE: src/gssr_queue.sv
module gssr_queue import gssr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  star_job_t push_data,
	input  logic      pop,
	output star_job_t head,
	output q_status_t q_stat
);

	star_job_t        mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.valid = (count_q != '0);
	assign q_stat.full  = (count_q == CNT_W'(QDEPTH));
	assign q_stat.count = count_q;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: src/gssr_back.sv
module gssr_back import gssr_pkg::*; #(
	parameter int WINDOW_RADIUS = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  star_job_t                 head,
	input  q_status_t                 q_stat,
	input  logic [DIM_W-1:0]          image_height,
	output logic                      pop,
	output logic                      row_valid,
	input  logic                      row_ready,
	output logic signed [COORD_W-1:0] row_index,
	output logic signed [COORD_W-1:0] first_column,
	output logic [SPAN_MAX-1:0]       write_mask,
	output logic [LOW_PIX*PIX_W-1:0]  pixels_low,
	output logic [(SPAN_MAX-LOW_PIX)*PIX_W-1:0] pixels_high,
	output logic                      last_row
);

	localparam int SPAN  = 2 * WINDOW_RADIUS + 1;
	localparam int RW    = $clog2(SPAN);
	localparam int RDY_W = RW + 1;

	logic [RW-1:0]                   r_q;
	logic                            row_valid_q;
	logic signed [COORD_W-1:0]       row_index_q;
	logic signed [COORD_W-1:0]       first_column_q;
	logic [SPAN_MAX-1:0]             write_mask_q;
	logic [SPAN_MAX-1:0][PIX_W-1:0]  pix_q;
	logic                            last_row_q;

	logic                            advance;
	logic                            last;
	logic signed [RDY_W-1:0]         dy;
	logic signed [DIST_W-1:0]        dy6;
	logic [DIST_W-1:0]               dy_sq;
	logic signed [COORD_W-1:0]       row;
	logic                            row_in;
	logic [SPAN_MAX-1:0][PIX_W-1:0]  pix;

	assign advance = !row_valid_q || row_ready;
	assign last    = (r_q == RW'(SPAN - 1));
	assign pop     = advance && q_stat.valid && last;

	// Row geometry for the current window line.
	assign dy     = $signed({1'b0, r_q}) - RDY_W'(WINDOW_RADIUS);
	assign dy6    = DIST_W'(dy);
	assign dy_sq  = DIST_W'(dy6 * dy6);
	assign row    = COORD_W'(head.star_y) + COORD_W'(dy);
	assign row_in = (row >= 0) && (row < $signed({2'b00, image_height}));

	// One intensity lookup per window pixel; pixels past the span stay zero.
	for (genvar k = 0; k < SPAN_MAX; k++) begin : g_pix
		if (k < SPAN) begin : g_on
			localparam int DX = k - WINDOW_RADIUS;
			localparam logic [DIST_W-1:0] DX_SQ = DIST_W'(DX * DX);
			logic [DIST_W-1:0]     dist_sq;
			logic signed [N_W-1:0] n;
			assign dist_sq = DX_SQ + dy_sq;
			assign n       = N_W'(head.n_base) +
				$signed(N_W'({dist_sq, {DIST_SHIFT{1'b0}}}));
			assign pix[k]  = pixel_level(n);
		end else begin : g_off
			assign pix[k] = '0;
		end
	end

	// Row sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= 1'b0;
			r_q         <= '0;
		end else if (advance) begin
			row_valid_q <= q_stat.valid;
			if (q_stat.valid) begin
				r_q <= last ? '0 : r_q + 1'b1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (advance && q_stat.valid) begin
			row_index_q    <= row;
			first_column_q <= head.first_col;
			write_mask_q   <= row_in ? head.col_mask : '0;
			pix_q          <= pix;
			last_row_q     <= last;
		end
	end

	assign row_valid    = row_valid_q;
	assign row_index    = row_index_q;
	assign first_column = first_column_q;
	assign write_mask   = write_mask_q;
	assign pixels_low   = pix_q[LOW_PIX-1:0];
	assign pixels_high  = pix_q[SPAN_MAX-1:LOW_PIX];
	assign last_row     = last_row_q;

endmodule

FILE: src/gaussian_star_spot_render_unit.sv
// Gaussian star spot renderer: one star in, 2*WINDOW_RADIUS+1 window rows out.
// The first row of a star passes the front holding stage, the queue and the back
// output register. Rows go out one per cycle while row_ready is high, set by the
// row sequencer; a star gives 2*WINDOW_RADIUS+1 rows (11 at the default radius).
// Reset: arst_n clears all valid flags, the queue and the row counter, and sets
// image_width and image_height to 1400.
module gaussian_star_spot_render_unit import gssr_pkg::*; #(
	parameter int WINDOW_RADIUS = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         star_valid,
	output logic                         star_ready,
	input  logic signed [COORD_IN_W-1:0] star_x,
	input  logic signed [COORD_IN_W-1:0] star_y,
	input  logic signed [MAG_W-1:0]      star_magnitude,
	output logic                         row_valid,
	input  logic                         row_ready,
	output logic signed [COORD_W-1:0]    row_index,
	output logic signed [COORD_W-1:0]    first_column,
	output logic [SPAN_MAX-1:0]          write_mask,
	output logic [LOW_PIX*PIX_W-1:0]     pixels_low,
	output logic [(SPAN_MAX-LOW_PIX)*PIX_W-1:0] pixels_high,
	output logic                         last_row
);

	localparam int SPAN = 2 * WINDOW_RADIUS + 1;
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;
	localparam logic [DIM_W-1:0] DIM_RESET = 12'd1400;

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic             cfg_wr;
	logic             push;
	logic             pop;
	star_job_t        front_job;
	star_job_t        head;
	q_status_t        q_stat;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WIDTH:  prdata = {20'd0, width_q};
			REG_HEIGHT: prdata = {20'd0, height_q};
			default:    prdata = '0;
		endcase
	end

	gssr_front #(.WINDOW_RADIUS(WINDOW_RADIUS)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.star_valid     (star_valid),
		.star_ready     (star_ready),
		.star_x         (star_x),
		.star_y         (star_y),
		.star_magnitude (star_magnitude),
		.image_width    (width_q),
		.q_stat         (q_stat),
		.push           (push),
		.job            (front_job)
	);

	gssr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_job),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	gssr_back #(.WINDOW_RADIUS(WINDOW_RADIUS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_stat       (q_stat),
		.image_height (height_q),
		.pop          (pop),
		.row_valid    (row_valid),
		.row_ready    (row_ready),
		.row_index    (row_index),
		.first_column (first_column),
		.write_mask   (write_mask),
		.pixels_low   (pixels_low),
		.pixels_high  (pixels_high),
		.last_row     (last_row)
	);

	// A window is never cut short: a taken inner row is followed by the next one.
	assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && row_ready && !last_row |=> row_valid)
		else $error("window row sequence broken");

	// Consecutive rows of one window step down by one row at the same origin.
	assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && row_ready && !last_row |=>
		(row_index == $past(row_index) + 14'sd1) && (first_column == $past(first_column)))
		else $error("window row geometry inconsistent");

	// Pixels beyond the window span are never written.
	assert property (@(posedge clk) disable iff (!arst_n)
		row_valid |-> ((write_mask >> SPAN) == '0))
		else $error("mask set beyond window span");

	// The queue never holds more items than it has entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= CNT_W'(QDEPTH))
		else $error("queue overfilled");

endmodule

FILE: tb/sv/gaussian_star_spot_render_unit_tb.sv
`timescale 1ns / 1ps

import gssr_pkg::*;

// Keeps the image size and the rows each accepted star must still produce,
// and checks every returned row against the oldest one outstanding.
class spot_scoreboard;
	localparam int STEP_LIMIT = 200;
	localparam longint unsigned PEAK_Q24  = 64'd961263668779;
	localparam longint unsigned DECAY_Q24 = 64'd15760736;
	localparam longint unsigned ROUND_Q24 = 64'd8388608;

	typedef struct {
		logic [COORD_W-1:0]                  row_index;
		logic [COORD_W-1:0]                  first_column;
		logic [SPAN_MAX-1:0]                 write_mask;
		logic [LOW_PIX*PIX_W-1:0]            pixels_low;
		logic [(SPAN_MAX-LOW_PIX)*PIX_W-1:0] pixels_high;
		logic                                last_row;
	} spot_row_t;

	int unsigned      image_width;
	int unsigned      image_height;
	int               radius;
	int               errors;
	logic [PIX_W-1:0] decay_level [0:STEP_LIMIT];
	spot_row_t        rows_due [$];

	// The peak level decays by e^(-1/16) per step; tabulate every step count.
	function new(int window_radius);
		longint unsigned v;
		longint unsigned r;
		radius = window_radius;
		image_width = 1400;
		image_height = 1400;
		errors = 0;
		v = PEAK_Q24;
		for (int n = 0; n <= STEP_LIMIT; n++) begin
			r = (v + ROUND_Q24) >> 24;
			decay_level[n] = (r > 64'd255) ? 8'd255 : r[7:0];
			v = (v * DECAY_Q24 + ROUND_Q24) >> 24;
		end
	endfunction

	// Pixel intensity for an exponent in sixteenths.
	function logic [PIX_W-1:0] spot_level(int e16);
		if (e16 >= 0)
			return decay_level[0];
		if (-e16 > STEP_LIMIT)
			return '0;
		return decay_level[-e16];
	endfunction

	// Work out every window row of an accepted star.
	function void note_star(logic signed [COORD_IN_W-1:0] x, logic signed [COORD_IN_W-1:0] y,
			logic signed [MAG_W-1:0] magnitude);
		int                        span;
		int                        sx;
		int                        sy;
		int                        mag;
		int                        row;
		int                        col;
		int                        spread;
		bit                        row_in;
		logic [SPAN_MAX*PIX_W-1:0] pix;
		spot_row_t                 e;
		span = 2 * radius + 1;
		sx = x;
		sy = y;
		mag = magnitude;
		for (int r = 0; r < span; r++) begin
			row = sy + r - radius;
			row_in = row >= 0 && row < int'(image_height);
			pix = '0;
			e.write_mask = '0;
			for (int k = 0; k < span && k < SPAN_MAX; k++) begin
				col = sx - radius + k;
				spread = (k - radius) * (k - radius) + (r - radius) * (r - radius);
				pix[PIX_W*k +: PIX_W] = spot_level(16 - mag - 32 * spread);
				if (row_in && col >= 0 && col < int'(image_width))
					e.write_mask[k] = 1'b1;
			end
			e.row_index = COORD_W'(row);
			e.first_column = COORD_W'(sx - radius);
			e.pixels_low = pix[LOW_PIX*PIX_W-1:0];
			e.pixels_high = pix[SPAN_MAX*PIX_W-1:LOW_PIX*PIX_W];
			e.last_row = (r == span - 1);
			rows_due.push_back(e);
		end
	endfunction

	function void check_field(string field, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			errors++;
		end
	endfunction

	// Compare a returned row with the oldest row still outstanding.
	function void check_row(logic [COORD_W-1:0] row_index, logic [COORD_W-1:0] first_column,
			logic [SPAN_MAX-1:0] write_mask, logic [LOW_PIX*PIX_W-1:0] pixels_low,
			logic [(SPAN_MAX-LOW_PIX)*PIX_W-1:0] pixels_high, logic last_row);
		spot_row_t e;
		if (rows_due.size() == 0) begin
			$error("row 0x%0h returned with no star outstanding", row_index);
			errors++;
			return;
		end
		e = rows_due.pop_front();
		check_field("row_index", e.row_index, row_index);
		check_field("first_column", e.first_column, first_column);
		check_field("write_mask", e.write_mask, write_mask);
		check_field("pixels_low", e.pixels_low, pixels_low);
		check_field("pixels_high", e.pixels_high, pixels_high);
		check_field("last_row", e.last_row, last_row);
	endfunction

	function int pending();
		return rows_due.size();
	endfunction
endclass

module gaussian_star_spot_render_unit_tb;

	localparam int SPOT_RADIUS    = 5;
	localparam int CLK_HALF       = 5;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int COORD_MIN      = -(1 << (COORD_IN_W - 1));
	localparam int COORD_MAX      = (1 << (COORD_IN_W - 1)) - 1;

	localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd4;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                psel = 1'b0;
	logic                                penable = 1'b0;
	logic                                pwrite = 1'b0;
	logic [2:0]                          paddr = '0;
	logic [31:0]                         pwdata = '0;
	logic [31:0]                         prdata;
	logic                                pready;
	logic                                star_valid = 1'b0;
	logic                                star_ready;
	logic signed [COORD_IN_W-1:0]        star_x = '0;
	logic signed [COORD_IN_W-1:0]        star_y = '0;
	logic signed [MAG_W-1:0]             star_magnitude = '0;
	logic                                row_valid;
	logic                                row_ready = 1'b0;
	logic signed [COORD_W-1:0]           row_index;
	logic signed [COORD_W-1:0]           first_column;
	logic [SPAN_MAX-1:0]                 write_mask;
	logic [LOW_PIX*PIX_W-1:0]            pixels_low;
	logic [(SPAN_MAX-LOW_PIX)*PIX_W-1:0] pixels_high;
	logic                                last_row;

	spot_scoreboard sb;
	bit             idle_on = 1'b1;
	int             stall_left = 0;
	int             quiet_cycles = 0;

	gaussian_star_spot_render_unit #(
		.WINDOW_RADIUS(SPOT_RADIUS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.star_valid(star_valid),
		.star_ready(star_ready),
		.star_x(star_x),
		.star_y(star_y),
		.star_magnitude(star_magnitude),
		.row_valid(row_valid),
		.row_ready(row_ready),
		.row_index(row_index),
		.first_column(first_column),
		.write_mask(write_mask),
		.pixels_low(pixels_low),
		.pixels_high(pixels_high),
		.last_row(last_row)
	);

	always #CLK_HALF clk = ~clk;

	// Row receiver: check each accepted item, then decide whether to stall.
	always @(posedge clk) begin
		if (arst_n && row_valid && row_ready)
			sb.check_row(row_index, first_column, write_mask, pixels_low, pixels_high, last_row);
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			row_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 16);
			row_ready <= 1'b0;
		end else begin
			row_ready <= 1'b1;
		end
	end

	// Watchdog: the run is stuck when no item moves on either side for too long.
	always @(posedge clk) begin
		if ((star_valid && star_ready) || (row_valid && row_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("gaussian_star_spot_render_unit_tb NOT OK");
				$finish;
			end
		end
	end

	// Register write; the bus stays selected so that transfers may follow directly.
	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic reg_read_check(input logic [2:0] addr, input int unsigned want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== 32'(want)) begin
			$error("register 0x%0h: expected %0d, got %0d", addr, want, prdata);
			sb.errors++;
		end
	endtask

	task automatic bus_release();
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Set the image size; the upper data bits carry noise that must be dropped.
	task automatic set_image(input int unsigned w, input int unsigned h);
		logic [31:0] word;
		word = $urandom();
		word[DIM_W-1:0] = w[DIM_W-1:0];
		reg_write(REG_IMAGE_WIDTH, word);
		word = $urandom();
		word[DIM_W-1:0] = h[DIM_W-1:0];
		reg_write(REG_IMAGE_HEIGHT, word);
		sb.image_width = w;
		sb.image_height = h;
		reg_read_check(REG_IMAGE_WIDTH, w);
		reg_read_check(REG_IMAGE_HEIGHT, h);
		bus_release();
	endtask

	// Offer one star, possibly after an idle burst, and hold it until taken.
	task automatic send_star(input logic signed [COORD_IN_W-1:0] x,
			input logic signed [COORD_IN_W-1:0] y, input logic signed [MAG_W-1:0] m);
		if (idle_on && $urandom_range(0, 2) == 0) begin
			star_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		star_valid <= 1'b1;
		star_x <= x;
		star_y <= y;
		star_magnitude <= m;
		do @(posedge clk); while (!star_ready);
		sb.note_star(x, y, m);
	endtask

	// Hold off the sender until every outstanding row has come back.
	task automatic drain();
		star_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Coordinates mostly around the image and its edges, some anywhere.
	function automatic logic signed [COORD_IN_W-1:0] pick_coord(input int extent);
		int c;
		case ($urandom_range(0, 3))
			0, 1: c = int'($urandom_range(0, extent + 11)) - 6;
			2: c = ($urandom_range(0, 1) ? extent : 0) + int'($urandom_range(0, 11)) - 6;
			default: c = int'($urandom_range(0, 8191)) + COORD_MIN;
		endcase
		if (c > COORD_MAX)
			c = COORD_MAX;
		if (c < COORD_MIN)
			c = COORD_MIN;
		return COORD_IN_W'(c);
	endfunction

	// Half over -128 to 255, half where the spot is visible.
	function automatic logic signed [MAG_W-1:0] pick_magnitude();
		int m;
		if ($urandom_range(0, 1))
			m = int'($urandom_range(0, 383)) - 128;
		else
			m = int'($urandom_range(0, 140)) - 16;
		return MAG_W'(m);
	endfunction

	task automatic send_random_star();
		send_star(pick_coord(int'(sb.image_width)), pick_coord(int'(sb.image_height)),
			pick_magnitude());
	endtask

	// One image size, with a full drain half way through.
	task automatic run_phase(input int unsigned w, input int unsigned h, input int count);
		drain();
		set_image(w, h);
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				drain();
			send_random_star();
		end
	endtask

	initial begin
		sb = new(SPOT_RADIUS);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values of the image size.
		reg_read_check(REG_IMAGE_WIDTH, 1400);
		reg_read_check(REG_IMAGE_HEIGHT, 1400);
		bus_release();

		// Corners, edges, extremes of the coordinate fields and the decay boundaries.
		send_star(0, 0, -128);
		send_star(1399, 1399, 16);
		send_star(1400, 1400, 17);
		send_star(-5, 700, 0);
		send_star(1404, 700, 0);
		send_star(-6, -6, 0);
		send_star(4095, 4095, 255);
		send_star(-4096, -4096, -128);
		send_star(700, -1, 32);
		send_star(700, 1405, 48);
		send_star(100, 100, 202);
		send_star(100, 100, 203);
		send_star(100, 100, 216);
		send_star(100, 100, 217);
		send_star(100, 100, 15);
		send_star(100, 100, 16);
		send_star(-1, -1, -1);
		send_star(4095, -4096, 100);
		for (int i = 0; i < 42; i++)
			send_random_star();

		// Sizes from the smallest to the largest, zero included.
		run_phase(1, 1, 50);
		run_phase(4095, 4095, 60);
		run_phase(0, 0, 30);
		run_phase(4095, 0, 20);
		run_phase($urandom_range(1, 64), $urandom_range(1, 64), 60);
		run_phase(4095, 1, 50);
		run_phase(1, 4095, 40);
		run_phase($urandom_range(1, 4095), $urandom_range(1, 4095), 60);

		// Final stretch at full rate on both sides.
		idle_on = 1'b0;
		run_phase($urandom_range(1, 40), $urandom_range(1, 40), 80);
		drain();

		if (sb.errors == 0)
			$display("gaussian_star_spot_render_unit_tb OK");
		else
			$display("gaussian_star_spot_render_unit_tb NOT OK");
		$finish;
	end

endmodule
